>>> hdl/nfcs_pkg.sv
// Shared types, codes and step table for the NOR flash command sequencer.
package nfcs_pkg;

	localparam int ADDR_W    = 26;
	localparam int OFF_W     = 23;
	localparam int WORD_W    = 16;
	localparam int REQ_W     = 3;
	localparam int OP_W      = 3;
	localparam int KIND_W    = 4;
	localparam int IDX_W     = 4;
	localparam int OSEL_W    = 3;
	localparam int VSEL_W    = 4;
	localparam int QUEUE_DEPTH = 2;

	localparam int WINDOW_BYTES_LOG2_DEF = 23;
	localparam int BUFFER_WORDS_DEF      = 16;

	// request types
	localparam logic [REQ_W-1:0] REQ_RESET    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_BLK_ERASE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_CHIP_ERASE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_PROGRAM  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_BUF_START = 3'd4;
	localparam logic [REQ_W-1:0] REQ_BUF_WORD = 3'd5;
	localparam logic [REQ_W-1:0] REQ_POLL     = 3'd6;

	// bus operations
	localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
	localparam logic [OP_W-1:0] OP_READ   = 3'd1;
	localparam logic [OP_W-1:0] OP_PAGE   = 3'd2;
	localparam logic [OP_W-1:0] OP_DONE   = 3'd3;
	localparam logic [OP_W-1:0] OP_REJECT = 3'd4;

	// front modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_POLL = 2'd1;
	localparam logic [1:0] MODE_FILL = 2'd2;

	// job kinds passed from front to back
	localparam logic [KIND_W-1:0] K_RESET     = 4'd0;
	localparam logic [KIND_W-1:0] K_RESET_PG  = 4'd1;
	localparam logic [KIND_W-1:0] K_BLK       = 4'd2;
	localparam logic [KIND_W-1:0] K_CHIP      = 4'd3;
	localparam logic [KIND_W-1:0] K_PROG      = 4'd4;
	localparam logic [KIND_W-1:0] K_BSTART    = 4'd5;
	localparam logic [KIND_W-1:0] K_BWORD     = 4'd6;
	localparam logic [KIND_W-1:0] K_BWORD_END = 4'd7;
	localparam logic [KIND_W-1:0] K_READ      = 4'd8;
	localparam logic [KIND_W-1:0] K_SUBER     = 4'd9;
	localparam logic [KIND_W-1:0] K_DONE      = 4'd10;
	localparam logic [KIND_W-1:0] K_DONE_PG   = 4'd11;
	localparam logic [KIND_W-1:0] K_REJECT    = 4'd12;

	// offset selects
	localparam logic [OSEL_W-1:0] O_ZERO = 3'd0;
	localparam logic [OSEL_W-1:0] O_AAA  = 3'd1;
	localparam logic [OSEL_W-1:0] O_554  = 3'd2;
	localparam logic [OSEL_W-1:0] O_A    = 3'd3;
	localparam logic [OSEL_W-1:0] O_B    = 3'd4;

	// value selects
	localparam logic [VSEL_W-1:0] V_ZERO = 4'd0;
	localparam logic [VSEL_W-1:0] V_PAGE = 4'd1;
	localparam logic [VSEL_W-1:0] V_F0   = 4'd2;
	localparam logic [VSEL_W-1:0] V_AA   = 4'd3;
	localparam logic [VSEL_W-1:0] V_55   = 4'd4;
	localparam logic [VSEL_W-1:0] V_80   = 4'd5;
	localparam logic [VSEL_W-1:0] V_30   = 4'd6;
	localparam logic [VSEL_W-1:0] V_10   = 4'd7;
	localparam logic [VSEL_W-1:0] V_A0   = 4'd8;
	localparam logic [VSEL_W-1:0] V_25   = 4'd9;
	localparam logic [VSEL_W-1:0] V_29   = 4'd10;
	localparam logic [VSEL_W-1:0] V_DATA = 4'd11;

	localparam logic [OFF_W-1:0]  CMD_ADDR_A      = 23'h000AAA;
	localparam logic [OFF_W-1:0]  CMD_ADDR_B      = 23'h000554;
	localparam logic [OFF_W-1:0]  SUBSECTOR_BYTES = 23'h008000;
	localparam logic [ADDR_W-1:0] TOP_BLOCK       = 26'h3FE0000;

	localparam logic [WORD_W-1:0] CMD_F0 = 16'h00F0;
	localparam logic [WORD_W-1:0] CMD_AA = 16'h00AA;
	localparam logic [WORD_W-1:0] CMD_55 = 16'h0055;
	localparam logic [WORD_W-1:0] CMD_80 = 16'h0080;
	localparam logic [WORD_W-1:0] CMD_30 = 16'h0030;
	localparam logic [WORD_W-1:0] CMD_10 = 16'h0010;
	localparam logic [WORD_W-1:0] CMD_A0 = 16'h00A0;
	localparam logic [WORD_W-1:0] CMD_25 = 16'h0025;
	localparam logic [WORD_W-1:0] CMD_29 = 16'h0029;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [WORD_W-1:0] page;
		logic [OFF_W-1:0]  off_a;
		logic [OFF_W-1:0]  off_b;
		logic [WORD_W-1:0] data;
	} job_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [OSEL_W-1:0] osel;
		logic [VSEL_W-1:0] vsel;
		logic              last;
	} step_t;

	function automatic step_t mk(logic [OP_W-1:0] op, logic [OSEL_W-1:0] osel,
			logic [VSEL_W-1:0] vsel, logic last);
		step_t s;
		s.op   = op;
		s.osel = osel;
		s.vsel = vsel;
		s.last = last;
		return s;
	endfunction

	// erase command body: AA 55 80 AA 55, final command, then a read
	function automatic step_t erase_step(logic [IDX_W-1:0] i, logic [OSEL_W-1:0] fin_off,
			logic [VSEL_W-1:0] fin_val, logic [OSEL_W-1:0] rd_off);
		step_t s;
		unique case (i)
			4'd0:    s = mk(OP_WRITE, O_AAA, V_AA, 1'b0);
			4'd1:    s = mk(OP_WRITE, O_554, V_55, 1'b0);
			4'd2:    s = mk(OP_WRITE, O_AAA, V_80, 1'b0);
			4'd3:    s = mk(OP_WRITE, O_AAA, V_AA, 1'b0);
			4'd4:    s = mk(OP_WRITE, O_554, V_55, 1'b0);
			4'd5:    s = mk(OP_WRITE, fin_off, fin_val, 1'b0);
			default: s = mk(OP_READ, rd_off, V_ZERO, 1'b1);
		endcase
		return s;
	endfunction

	function automatic step_t seq_step(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] i);
		step_t s;
		unique case (kind)
			K_RESET:    s = mk(OP_WRITE, O_ZERO, V_F0, 1'b1);
			K_RESET_PG: s = (i == 4'd0) ? mk(OP_PAGE, O_ZERO, V_PAGE, 1'b0)
				: mk(OP_WRITE, O_ZERO, V_F0, 1'b1);
			K_BLK: begin
				unique case (i)
					4'd0:    s = mk(OP_PAGE, O_ZERO, V_PAGE, 1'b0);
					4'd1:    s = mk(OP_WRITE, O_ZERO, V_F0, 1'b0);
					default: s = erase_step(i - 4'd2, O_A, V_30, O_A);
				endcase
			end
			K_CHIP:  s = erase_step(i, O_AAA, V_10, O_ZERO);
			K_SUBER: s = erase_step(i, O_A, V_30, O_A);
			K_PROG: begin
				unique case (i)
					4'd0:    s = mk(OP_PAGE, O_ZERO, V_PAGE, 1'b0);
					4'd1:    s = mk(OP_WRITE, O_ZERO, V_F0, 1'b0);
					4'd2:    s = mk(OP_WRITE, O_AAA, V_AA, 1'b0);
					4'd3:    s = mk(OP_WRITE, O_554, V_55, 1'b0);
					4'd4:    s = mk(OP_WRITE, O_AAA, V_A0, 1'b0);
					4'd5:    s = mk(OP_WRITE, O_A, V_DATA, 1'b0);
					default: s = mk(OP_READ, O_A, V_ZERO, 1'b1);
				endcase
			end
			K_BSTART: begin
				unique case (i)
					4'd0:    s = mk(OP_PAGE, O_ZERO, V_PAGE, 1'b0);
					4'd1:    s = mk(OP_WRITE, O_ZERO, V_F0, 1'b0);
					4'd2:    s = mk(OP_WRITE, O_AAA, V_AA, 1'b0);
					4'd3:    s = mk(OP_WRITE, O_554, V_55, 1'b0);
					4'd4:    s = mk(OP_WRITE, O_A, V_25, 1'b0);
					default: s = mk(OP_WRITE, O_A, V_DATA, 1'b1);
				endcase
			end
			K_BWORD: s = mk(OP_WRITE, O_A, V_DATA, 1'b1);
			K_BWORD_END: begin
				unique case (i)
					4'd0:    s = mk(OP_WRITE, O_A, V_DATA, 1'b0);
					4'd1:    s = mk(OP_WRITE, O_B, V_29, 1'b0);
					default: s = mk(OP_READ, O_A, V_ZERO, 1'b1);
				endcase
			end
			K_READ:    s = mk(OP_READ, O_A, V_ZERO, 1'b1);
			K_DONE:    s = mk(OP_DONE, O_ZERO, V_ZERO, 1'b1);
			K_DONE_PG: s = (i == 4'd0) ? mk(OP_PAGE, O_ZERO, V_PAGE, 1'b0)
				: mk(OP_DONE, O_ZERO, V_ZERO, 1'b1);
			default:   s = mk(OP_REJECT, O_ZERO, V_ZERO, 1'b1);
		endcase
		return s;
	endfunction

endpackage

>>> hdl/nfcs_front.sv
// Request front end: mode tracking, classification and job generation.
module nfcs_front
	import nfcs_pkg::*;
#(
	parameter int WINDOW_BYTES_LOG2 = WINDOW_BYTES_LOG2_DEF,
	parameter int BUFFER_WORDS      = BUFFER_WORDS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [REQ_W-1:0]  req_type,
	input  logic [ADDR_W-1:0] flash_address,
	input  logic [WORD_W-1:0] word_data,
	input  logic              q_full,
	output logic              push,
	output job_t              push_job
);

	localparam int OFF_BITS = (WINDOW_BYTES_LOG2 < OFF_W) ? WINDOW_BYTES_LOG2 : OFF_W;
	localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((64'd1 << OFF_BITS) - 64'd1);
	localparam int CNT_W = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(BUFFER_WORDS - 1);

	logic [WORD_W-1:0] base_page_q;
	logic [1:0]        mode_q, mode_d;
	logic              page_changed_q, page_changed_d;
	logic [OFF_W-1:0]  sector_offset_q, sector_offset_d;
	logic [1:0]        subsectors_left_q, subsectors_left_d;
	logic [OFF_W-1:0]  poll_offset_q, poll_offset_d;
	logic [WORD_W-1:0] first_read_q, first_read_d;
	logic              have_first_q, have_first_d;
	logic [CNT_W-1:0]  buffer_count_q, buffer_count_d;

	logic [ADDR_W-1:0] blk;
	logic [WORD_W-1:0] win_page;
	logic [OFF_W-1:0]  win_off;
	logic [OFF_W-1:0]  buf_off;
	logic [OFF_W-1:0]  sub_off;
	logic              accept;
	logic              is_idle;
	job_t              job;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept;
	assign push_job = job;
	assign is_idle  = (mode_q == MODE_IDLE);

	assign blk      = flash_address >> WINDOW_BYTES_LOG2;
	assign win_page = base_page_q + {blk[3:0], 12'h000};
	assign win_off  = flash_address[OFF_W-1:0] & OFF_MASK;
	assign buf_off  = (sector_offset_q + OFF_W'({buffer_count_q, 1'b0})) & OFF_MASK;
	assign sub_off  = (sector_offset_q + SUBSECTOR_BYTES) & OFF_MASK;

	always_comb begin
		mode_d            = mode_q;
		page_changed_d    = page_changed_q;
		sector_offset_d   = sector_offset_q;
		subsectors_left_d = subsectors_left_q;
		poll_offset_d     = poll_offset_q;
		first_read_d      = first_read_q;
		have_first_d      = have_first_q;
		buffer_count_d    = buffer_count_q;
		job.kind  = K_REJECT;
		job.page  = base_page_q;
		job.off_a = win_off;
		job.off_b = sector_offset_q;
		job.data  = word_data;
		priority if (req_type == REQ_RESET) begin
			job.kind          = page_changed_q ? K_RESET_PG : K_RESET;
			mode_d            = MODE_IDLE;
			page_changed_d    = 1'b0;
			sector_offset_d   = '0;
			subsectors_left_d = '0;
			poll_offset_d     = '0;
			first_read_d      = '0;
			have_first_d      = 1'b0;
			buffer_count_d    = '0;
		end else if (req_type == REQ_BLK_ERASE && is_idle) begin
			job.kind          = K_BLK;
			job.page          = win_page;
			page_changed_d    = 1'b1;
			sector_offset_d   = win_off;
			subsectors_left_d = (flash_address == '0 || flash_address == TOP_BLOCK)
				? 2'd3 : 2'd0;
			mode_d            = MODE_POLL;
			poll_offset_d     = win_off;
			have_first_d      = 1'b0;
			first_read_d      = '0;
		end else if (req_type == REQ_CHIP_ERASE && is_idle) begin
			job.kind          = K_CHIP;
			sector_offset_d   = '0;
			subsectors_left_d = '0;
			mode_d            = MODE_POLL;
			poll_offset_d     = '0;
			have_first_d      = 1'b0;
			first_read_d      = '0;
		end else if (req_type == REQ_PROGRAM && is_idle) begin
			job.kind          = K_PROG;
			job.page          = win_page;
			page_changed_d    = 1'b1;
			subsectors_left_d = '0;
			mode_d            = MODE_POLL;
			poll_offset_d     = win_off;
			have_first_d      = 1'b0;
			first_read_d      = '0;
		end else if (req_type == REQ_BUF_START && is_idle) begin
			job.kind          = K_BSTART;
			job.page          = win_page;
			job.data          = WORD_W'(BUFFER_WORDS - 1);
			page_changed_d    = 1'b1;
			subsectors_left_d = '0;
			sector_offset_d   = win_off;
			buffer_count_d    = '0;
			mode_d            = MODE_FILL;
		end else if (req_type == REQ_BUF_WORD && mode_q == MODE_FILL) begin
			job.off_a = buf_off;
			if (buffer_count_q >= CNT_LAST) begin
				// final word lands at the last buffer slot, which is also the poll spot
				job.kind       = K_BWORD_END;
				buffer_count_d = '0;
				mode_d         = MODE_POLL;
				poll_offset_d  = buf_off;
				have_first_d   = 1'b0;
				first_read_d   = '0;
			end else begin
				job.kind       = K_BWORD;
				buffer_count_d = buffer_count_q + 1'b1;
			end
		end else if (req_type == REQ_POLL && mode_q == MODE_POLL) begin
			job.off_a = poll_offset_q;
			if (!have_first_q) begin
				job.kind     = K_READ;
				first_read_d = word_data;
				have_first_d = 1'b1;
			end else if (first_read_q != word_data) begin
				job.kind     = K_READ;
				first_read_d = '0;
				have_first_d = 1'b0;
			end else if (subsectors_left_q != 2'd0) begin
				// next 32 KiB sub-sector of a boot block
				job.kind          = K_SUBER;
				job.off_a         = sub_off;
				subsectors_left_d = subsectors_left_q - 2'd1;
				sector_offset_d   = sub_off;
				poll_offset_d     = sub_off;
				first_read_d      = '0;
				have_first_d      = 1'b0;
			end else begin
				job.kind       = page_changed_q ? K_DONE_PG : K_DONE;
				first_read_d   = '0;
				have_first_d   = 1'b0;
				mode_d         = MODE_IDLE;
				page_changed_d = 1'b0;
			end
		end else begin
			job.kind = K_REJECT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_page_q       <= '0;
			mode_q            <= MODE_IDLE;
			page_changed_q    <= 1'b0;
			sector_offset_q   <= '0;
			subsectors_left_q <= '0;
			poll_offset_q     <= '0;
			first_read_q      <= '0;
			have_first_q      <= 1'b0;
			buffer_count_q    <= '0;
		end else begin
			if (cfg_valid) begin
				base_page_q <= cfg_data;
			end
			if (accept) begin
				mode_q            <= mode_d;
				page_changed_q    <= page_changed_d;
				sector_offset_q   <= sector_offset_d;
				subsectors_left_q <= subsectors_left_d;
				poll_offset_q     <= poll_offset_d;
				first_read_q      <= first_read_d;
				have_first_q      <= have_first_d;
				buffer_count_q    <= buffer_count_d;
			end
		end
	end

endmodule

>>> hdl/nfcs_queue.sv
// Two-entry job queue between the front end and the bus sequencer.
module nfcs_queue
	import nfcs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output job_t head_job
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/nfcs_back.sv
// Bus sequencer: expands one job into bus beats through an output register.
module nfcs_back
	import nfcs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  job_t              head_job,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OP_W-1:0]   bus_op,
	output logic [OFF_W-1:0]  bus_offset,
	output logic [WORD_W-1:0] bus_value,
	output logic              out_last
);

	logic [IDX_W-1:0]  idx_q;
	logic              out_valid_q;
	logic [OP_W-1:0]   op_q;
	logic [OFF_W-1:0]  offset_q;
	logic [WORD_W-1:0] value_q;
	logic              last_q;
	logic              load;
	step_t             st;
	logic [OFF_W-1:0]  off_n;
	logic [WORD_W-1:0] val_n;

	assign load = head_valid && (!out_valid_q || out_ready);
	assign pop  = load && st.last;
	assign st   = seq_step(head_job.kind, idx_q);

	always_comb begin
		unique case (st.osel)
			O_AAA:   off_n = CMD_ADDR_A;
			O_554:   off_n = CMD_ADDR_B;
			O_A:     off_n = head_job.off_a;
			O_B:     off_n = head_job.off_b;
			default: off_n = '0;
		endcase
		unique case (st.vsel)
			V_PAGE:  val_n = head_job.page;
			V_F0:    val_n = CMD_F0;
			V_AA:    val_n = CMD_AA;
			V_55:    val_n = CMD_55;
			V_80:    val_n = CMD_80;
			V_30:    val_n = CMD_30;
			V_10:    val_n = CMD_10;
			V_A0:    val_n = CMD_A0;
			V_25:    val_n = CMD_25;
			V_29:    val_n = CMD_29;
			V_DATA:  val_n = head_job.data;
			default: val_n = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= st.last ? '0 : idx_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q     <= st.op;
			offset_q <= off_n;
			value_q  <= val_n;
			last_q   <= st.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign bus_op     = op_q;
	assign bus_offset = offset_q;
	assign bus_value  = value_q;
	assign out_last   = last_q;

endmodule

>>> hdl/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer.
//
// Requests enter on the s_axis channel (req_type in tuser, address and word in
// tdata); each one is classified against the current mode when its beat is
// taken and turned into a job. Rejected requests and state changes are settled
// right there, so a new request can be taken every cycle while the queue has
// room. The bus sequencer drains a two-entry job queue and sends one bus beat
// per cycle on m_axis while m_axis_tready is high: write, read, page select,
// done or reject (bus_op in tuser). tlast marks each request's final beat.
// A request gives 1 to 9 beats. The request passes through the job queue and
// the output register before its first beat appears on m_axis; further beats
// follow one per cycle while m_axis_tready is high, and the next request's
// beats start only after all beats of the current one (9 for a block erase).
// The base page register is written on the cfg channel, which is always ready.
// When m_axis stalls, the output register holds its beat, the queue fills and
// s_axis_tready drops once both entries are taken.
// Reset clears the mode to idle, the base page to zero and empties the queue.
module nor_flash_command_sequencer
	import nfcs_pkg::*;
#(
	parameter int WINDOW_BYTES_LOG2 = WINDOW_BYTES_LOG2_DEF,
	parameter int BUFFER_WORDS      = BUFFER_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,      // base_page
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // flash_address[25:0], word_data[41:26], zero pad
	input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // bus_offset[22:0], bus_value[38:23], zero pad
	output logic [2:0]  m_axis_tuser,  // bus_op[2:0]
	output logic        m_axis_tlast
);

	logic              q_full;
	logic              q_push;
	job_t              q_push_job;
	logic              q_pop;
	logic              q_head_valid;
	job_t              q_head_job;
	logic [OP_W-1:0]   bus_op;
	logic [OFF_W-1:0]  bus_offset;
	logic [WORD_W-1:0] bus_value;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	nfcs_front #(
		.WINDOW_BYTES_LOG2(WINDOW_BYTES_LOG2),
		.BUFFER_WORDS     (BUFFER_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.req_type     (s_axis_tuser),
		.flash_address(s_axis_tdata[25:0]),
		.word_data    (s_axis_tdata[41:26]),
		.q_full       (q_full),
		.push         (q_push),
		.push_job     (q_push_job)
	);

	nfcs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_push_job),
		.full      (q_full),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_job  (q_head_job)
	);

	nfcs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_head_valid),
		.head_job  (q_head_job),
		.pop       (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.bus_op    (bus_op),
		.bus_offset(bus_offset),
		.bus_value (bus_value),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, bus_value, bus_offset};
	assign m_axis_tuser = bus_op;

	// queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("job queue overflow");

	// done and reject always close their request
	a_end_beats_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (bus_op == OP_DONE || bus_op == OP_REJECT)) |-> m_axis_tlast)
		else $error("done or reject beat without tlast");

	// a job leaves the queue only on its final beat
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (m_axis_tvalid && m_axis_tlast))
		else $error("job popped without a final beat");

endmodule
